// ----- hdl/thoc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package thoc_pkg;

  localparam int TABLE_ENTRIES = 72;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int OHM_W         = 24;
  localparam int TEMP_W        = 10;
  // Holds five times a resistance difference.
  localparam int NUM_W         = OHM_W + 3;
  localparam int Q_W           = 3;

  localparam int BASE_TEMP     = -55;
  localparam int STEP_TEMP     = 5;

  localparam logic signed [TEMP_W-1:0] BASE_T = TEMP_W'(BASE_TEMP);
  localparam logic signed [TEMP_W-1:0] TOP_T  =
    TEMP_W'(BASE_TEMP + STEP_TEMP * (TABLE_ENTRIES - 1));
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam int ROM_LEN = 72;
  localparam logic [OHM_W-1:0] ROM_PAD = 24'd108;
  localparam logic [OHM_W-1:0] ROM_DATA [0:ROM_LEN-1] = '{
    24'd10723236, 24'd7366689, 24'd5132757, 24'd3624165, 24'd2591304, 24'd1874913,
    24'd1371886,  24'd1014545, 24'd757881,  24'd571590,  24'd435026,  24'd333964,
    24'd258497,   24'd201659,  24'd158499,  24'd125468,  24'd100000,  24'd80223,
    24'd64759,    24'd52589,   24'd42951,   24'd35272,   24'd29119,   24'd24161,
    24'd20144,    24'd16874,   24'd14198,   24'd11998,   24'd10181,   24'd8674,
    24'd7419,     24'd6369,    24'd5487,    24'd4744,    24'd4115,    24'd3581,
    24'd3126,     24'd2737,    24'd2404,    24'd2117,    24'd1869,    24'd1655,
    24'd1469,     24'd1307,    24'd1166,    24'd1043,    24'd935,     24'd839,
    24'd755,      24'd681,     24'd616,     24'd558,     24'd506,     24'd460,
    24'd419,      24'd382,     24'd349,     24'd320,     24'd293,     24'd269,
    24'd247,      24'd228,     24'd210,     24'd194,     24'd179,     24'd166,
    24'd154,      24'd143,     24'd133,     24'd124,     24'd116,     24'd108
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_HI,
    ST_CHK_LO,
    ST_SCAN,
    ST_SPAN,
    ST_NUM,
    ST_DIV,
    ST_FINISH
  } state_t;

  // Entries past the stored curve repeat its last resistance.
  function automatic logic [OHM_W-1:0] rom_ohms(input logic [IDX_W-1:0] idx);
    logic [OHM_W-1:0] val;
    if (int'(idx) < ROM_LEN) begin
      val = ROM_DATA[idx];
    end else begin
      val = ROM_PAD;
    end
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/thoc_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface thoc_in_if
  import thoc_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [OHM_W-1:0] resistance_ohms;

  modport source (output valid, output resistance_ohms, input ready);
  modport sink (input valid, input resistance_ohms, output ready);
endinterface

interface thoc_out_if
  import thoc_pkg::*;
  ;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_c;

  modport source (output valid, output temperature_c, input ready);
  modport sink (input valid, input temperature_c, output ready);
endinterface

`default_nettype wire

// ----- hdl/thermistor_ohm_to_celsius_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Converts a 100 kilohm NTC thermistor resistance (ohms) into whole degrees
// Celsius, clamped to -55..300, by linear interpolation between table points
// spaced 5 degrees apart. After acceptance a request passes through a check
// against the first table entry (a resistance at or above it goes straight to
// the load with -55), a check against the last one (at or below it gives 300),
// a scan that visits one table interval per cycle, span and numerator setup,
// three restoring division steps (the last one also forms the sum), and the
// load into the output register. All compares and subtractions run through a
// single 27-bit subtractor. A new request is taken on the cycle after the
// previous result has moved into the output register, even if the consumer
// has not yet taken it; the block takes no new request while one is still in
// progress. A result still held in the output register stalls the block in
// its final step until the consumer takes it.
module thermistor_ohm_to_celsius_unit
  import thoc_pkg::*;
(
  input  wire           clk,
  input  wire           rst_n,
  thoc_in_if.sink       in_ch,
  thoc_out_if.source    out_ch
);

  state_t state_r, state_nxt;

  logic [OHM_W-1:0]         r_r, r_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [NUM_W-1:0]         span_r, span_nxt;
  logic [NUM_W-1:0]         rem_r, rem_nxt;
  logic [Q_W-1:0]           q_r, q_nxt;
  logic [1:0]               bit_r, bit_nxt;
  logic signed [TEMP_W-1:0] res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [TEMP_W-1:0] out_temp_r, out_temp_nxt;

  // Shared subtractor.
  logic [NUM_W-1:0] sub_a, sub_b;
  logic [NUM_W:0]   sub_d;
  logic             sub_ge;
  logic [IDX_W-1:0] idx_p1;
  logic [OHM_W-1:0] rom_cur, rom_nxt_entry;
  logic             out_free;
  logic [TEMP_W-1:0] step_ofs;

  assign idx_p1        = idx_r + 1'b1;
  assign rom_cur       = rom_ohms(idx_r);
  assign rom_nxt_entry = rom_ohms(idx_p1);
  assign sub_d         = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge        = ~sub_d[NUM_W];
  assign out_free      = ~out_valid_r | out_ch.ready;
  assign step_ofs      = TEMP_W'({idx_r, 2'b00}) + TEMP_W'(idx_r);

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.temperature_c = out_temp_r;

  always_comb begin
    unique case (state_r)
      ST_CHK_HI: begin
        sub_a = NUM_W'(r_r);
        sub_b = NUM_W'(rom_ohms('0));
      end
      ST_CHK_LO: begin
        sub_a = NUM_W'(rom_ohms(LAST_IDX));
        sub_b = NUM_W'(r_r);
      end
      ST_SCAN: begin
        sub_a = NUM_W'(r_r);
        sub_b = NUM_W'(rom_nxt_entry);
      end
      ST_SPAN: begin
        sub_a = NUM_W'(rom_cur);
        sub_b = NUM_W'(rom_nxt_entry);
      end
      ST_NUM: begin
        sub_a = NUM_W'(rom_cur);
        sub_b = NUM_W'(r_r);
      end
      ST_DIV: begin
        sub_a = rem_r;
        sub_b = span_r << bit_r;
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_CHK_HI;
      ST_CHK_HI: state_nxt = sub_ge ? ST_FINISH : ST_CHK_LO;
      ST_CHK_LO: state_nxt = sub_ge ? ST_FINISH : ST_SCAN;
      ST_SCAN:   if (sub_ge) state_nxt = ST_SPAN;
      ST_SPAN:   state_nxt = ST_NUM;
      ST_NUM:    state_nxt = ST_DIV;
      ST_DIV:    if (bit_r == 2'd0) state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    r_nxt         = r_r;
    idx_nxt       = idx_r;
    span_nxt      = span_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    bit_nxt       = bit_r;
    res_nxt       = res_r;
    out_temp_nxt  = out_temp_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) r_nxt = in_ch.resistance_ohms;
      end
      ST_CHK_HI: begin
        if (sub_ge) res_nxt = BASE_T;
      end
      ST_CHK_LO: begin
        res_nxt = TOP_T;
        idx_nxt = '0;
      end
      ST_SCAN: begin
        if (!sub_ge) idx_nxt = idx_p1;
      end
      ST_SPAN: begin
        span_nxt = sub_d[NUM_W-1:0];
      end
      ST_NUM: begin
        // Numerator is five times (upper - input).
        rem_nxt = (sub_d[NUM_W-1:0] << 2) + sub_d[NUM_W-1:0];
        q_nxt   = '0;
        bit_nxt = 2'd2;
      end
      ST_DIV: begin
        if (sub_ge) begin
          rem_nxt        = sub_d[NUM_W-1:0];
          q_nxt[bit_r]   = 1'b1;
        end
        bit_nxt = bit_r - 1'b1;
        if (bit_r == 2'd0) begin
          res_nxt = BASE_T + $signed(step_ofs)
                    + $signed(TEMP_W'({q_r[Q_W-1:1], sub_ge}));
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    r_r        <= r_nxt;
    idx_r      <= idx_nxt;
    span_r     <= span_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    bit_r      <= bit_nxt;
    res_r      <= res_nxt;
    out_temp_r <= out_temp_nxt;
  end

endmodule

`default_nettype wire
